### sv/ssa_pkg.sv
package ssa_pkg;

    // Sequence capacity and the significant width of an input value.
    localparam int MAX_LEN     = 1024;
    localparam int VALUE_WIDTH = 32;

    // Fixed field widths of the channels and of the threshold register.
    localparam int VALUE_IN_W = 32;
    localparam int LEN_OUT_W  = 11;
    localparam int THR_W      = 32;

    localparam int VAL_EFF_W = (VALUE_WIDTH < VALUE_IN_W) ? VALUE_WIDTH : VALUE_IN_W;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);

    // A prefix of at most MAX_LEN values of VAL_EFF_W bits always fits here.
    localparam int PREFIX_W = VAL_EFF_W + ADDR_W + 1;
    localparam int CMP_W    = ((PREFIX_W > THR_W) ? PREFIX_W : THR_W) + 1;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_LEN - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_LEN);

    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic signed [PREFIX_W-1:0] t_prefix;
    typedef logic signed [CMP_W-1:0]    t_cmp;
    typedef logic signed [THR_W-1:0]    t_thr;
    typedef logic [LEN_OUT_W-1:0]       t_len_out;

    typedef struct packed {
        t_addr   idx;
        t_prefix prefix;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_entry data;
    } t_ram_wr;

    typedef struct packed {
        logic     found;
        t_len_out shortest_len;
        logic     overflow;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_res_ch;

    function automatic t_addr addr_next(input t_addr a);
        return (a == ADDR_LAST) ? '0 : a + t_addr'(1);
    endfunction

    function automatic t_addr addr_prev(input t_addr a);
        return (a == '0) ? ADDR_LAST : a - t_addr'(1);
    endfunction

endpackage

### sv/ssa_in_if.sv
interface ssa_in_if import ssa_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_IN_W-1:0] value;
    logic                         last;

    modport source(output valid, output value, output last, input ready);
    modport sink(input valid, input value, input last, output ready);
endinterface

### sv/ssa_out_if.sv
interface ssa_out_if import ssa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [LEN_OUT_W-1:0] shortest_len;
    logic                 overflow;

    modport source(output valid, output found, output shortest_len, output overflow,
                   input ready);
    modport sink(input valid, input found, input shortest_len, input overflow,
                 output ready);
endinterface

### sv/ssa_deque_ram.sv
module ssa_deque_ram import ssa_pkg::*; (
    input  logic    i_clk,
    input  t_ram_wr i_wr,
    input  t_addr   i_rd_a_addr,
    input  t_addr   i_rd_b_addr,
    output t_entry  o_rd_a_data,
    output t_entry  o_rd_b_data
);

    t_entry r_mem [MAX_LEN];
    t_entry r_rd_a;
    t_entry r_rd_b;

    // A read of the entry being written returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_a <= (i_wr.en && (i_wr.addr == i_rd_a_addr)) ? i_wr.data : r_mem[i_rd_a_addr];
        r_rd_b <= (i_wr.en && (i_wr.addr == i_rd_b_addr)) ? i_wr.data : r_mem[i_rd_b_addr];
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = r_rd_b;

endmodule

### sv/ssa_core.sv
module ssa_core import ssa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_thr        i_threshold,
    ssa_in_if.sink      i_in,
    output t_res_ch     o_res,
    input  logic        i_res_ready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_STEP = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state  r_state, n_state;
    t_prefix r_prefix, n_prefix;
    t_cnt    r_item_idx, n_item_idx;
    t_cnt    r_best_len, n_best_len;
    logic    r_best_valid, n_best_valid;
    t_addr   r_head, n_head;
    t_addr   r_tail, n_tail;
    t_cnt    r_count, n_count;
    logic    r_ovf, n_ovf;
    logic    r_last, n_last;

    t_entry  head_e;
    t_entry  back_e;
    t_ram_wr wr;
    logic    in_xfer;
    logic    front_hit;
    logic    back_hit;
    logic    whole_hit;
    t_cnt    cand_len;
    logic    cand_en;
    t_cmp    thr_ext;
    logic signed [VAL_EFF_W-1:0] v_in;

    ssa_deque_ram u_ram (
        .i_clk       (i_clk),
        .i_wr        (wr),
        .i_rd_a_addr (n_head),
        .i_rd_b_addr (addr_prev(n_tail)),
        .o_rd_a_data (head_e),
        .o_rd_b_data (back_e)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign v_in       = i_in.value[VAL_EFF_W-1:0];
    assign thr_ext    = t_cmp'(i_threshold);

    assign front_hit = (r_count != '0) &&
        ((t_cmp'(r_prefix) - t_cmp'(signed'(head_e.prefix))) >= thr_ext);
    assign back_hit  = (r_count != '0) && (r_prefix <= signed'(back_e.prefix));
    assign whole_hit = t_cmp'(r_prefix) >= thr_ext;

    always_comb begin
        n_state      = r_state;
        n_prefix     = r_prefix;
        n_item_idx   = r_item_idx;
        n_best_len   = r_best_len;
        n_best_valid = r_best_valid;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_last       = r_last;
        cand_en      = 1'b0;
        cand_len     = '0;
        wr.en        = 1'b0;
        wr.addr      = r_tail;
        wr.data.idx  = r_item_idx[ADDR_W-1:0];
        wr.data.prefix = r_prefix;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_last = i_in.last;
                    if (r_item_idx != CNT_FULL) begin
                        n_prefix = r_prefix + t_prefix'(v_in);
                        n_state  = S_STEP;
                    end else begin
                        n_ovf = 1'b1;
                        if (i_in.last) begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_STEP: begin
                // Front pops come first; a back pop leaves the head entry as it
                // is, so the front test stays false once it has failed.
                priority if (front_hit) begin
                    cand_en  = 1'b1;
                    cand_len = r_item_idx - t_cnt'(head_e.idx);
                    n_head   = addr_next(r_head);
                    n_count  = r_count - t_cnt'(1);
                end else if (back_hit) begin
                    n_tail  = addr_prev(r_tail);
                    n_count = r_count - t_cnt'(1);
                end else begin
                    wr.en      = 1'b1;
                    n_tail     = addr_next(r_tail);
                    n_count    = r_count + t_cnt'(1);
                    n_item_idx = r_item_idx + t_cnt'(1);
                    cand_en    = whole_hit;
                    cand_len   = r_item_idx + t_cnt'(1);
                    n_state    = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_prefix     = '0;
                    n_item_idx   = '0;
                    n_best_valid = 1'b0;
                    n_head       = '0;
                    n_tail       = '0;
                    n_count      = '0;
                    n_ovf        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cand_en && (!r_best_valid || (cand_len < r_best_len))) begin
            n_best_len   = cand_len;
            n_best_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prefix     <= '0;
            r_item_idx   <= '0;
            r_best_valid <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prefix     <= n_prefix;
            r_item_idx   <= n_item_idx;
            r_best_valid <= n_best_valid;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_len <= n_best_len;
        r_last     <= n_last;
    end

    assign o_res.valid             = (r_state == S_EMIT);
    assign o_res.data.found        = r_best_valid;
    assign o_res.data.shortest_len = r_best_valid ? t_len_out'(r_best_len) : '0;
    assign o_res.data.overflow     = r_ovf;

endmodule

### sv/shortest_subarray_sum_at_least.sv
// Shortest subarray with sum at least a threshold. Signed values arrive one per
// transfer on the input channel; the item with last set closes a sequence and
// causes exactly one result transfer carrying found, the length of the
// shortest window whose sum reaches the threshold (0 when none does), and an
// overflow flag that is set when items beyond the 1024-item capacity were
// dropped. The threshold register resets to 1; the user must write it with
// i_cfg_wr_en only while no sequence is in flight, as the block itself does
// not enforce this. Each accepted item is first added to the running prefix,
// then removes zero or more deque entries one at a time and ends with a push
// of its own entry, all paced by the read-modify-write of the deque memory,
// which serves one head read, one back read and one write per cycle. Every
// item is pushed once and removed at most once. A dropped item is not added
// to the prefix and only sets the overflow flag. After the last item of a
// sequence the core hands its result to the output register, which lets the
// next sequence start while the result waits to be taken.
module shortest_subarray_sum_at_least import ssa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [THR_W-1:0]  i_cfg_wr_data,
    ssa_in_if.sink            i_in,
    ssa_out_if.source         o_out
);

    t_thr    r_threshold;
    t_res_ch res;
    logic    res_ready;
    logic    r_out_valid;
    t_result r_out_data;

    // Threshold register, to be written only between sequences (unchecked).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= t_thr'(1);
        end else if (i_cfg_wr_en) begin
            r_threshold <= signed'(i_cfg_wr_data);
        end
    end

    ssa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_in        (i_in),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // The output register takes a new result when it is empty or is being
    // emptied in the same cycle.
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_data <= res.data;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out_data.found;
    assign o_out.shortest_len = r_out_data.shortest_len;
    assign o_out.overflow     = r_out_data.overflow;

`ifndef ASSERT_OFF
    // While a result is being handed over, no new item is taken.
    a_no_accept_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> !i_in.ready)
        else $error("input accepted while a result is pending");

    // A result handed to the output register is offered in the next cycle.
    a_result_offered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res_ready) |=> o_out.valid)
        else $error("result lost between core and output register");

    // A sequence with no qualifying window reports a length of zero.
    a_len_zero_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.shortest_len == '0))
        else $error("nonzero length reported without a window");
`endif

endmodule
